// File: rtl/afp_pkg.sv
// ----------------------------------------------------------------------------
// Adaptive frame pacer package
// Shared constants, register indexes and the control and result types.
// ----------------------------------------------------------------------------
package afp_pkg;

    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_MS        = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TIMESTAMP_STEP  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_LEAD        = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_LEAD        = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_TIMESTAMP_START = 3'd4;

    localparam logic [6:0]  RST_FRAME_MS        = 7'd20;
    localparam logic [15:0] RST_TIMESTAMP_STEP  = 16'd960;
    localparam logic [3:0]  RST_MIN_LEAD        = 4'd2;
    localparam logic [3:0]  RST_MAX_LEAD        = 4'd4;
    localparam logic [31:0] RST_TIMESTAMP_START = 32'd0;

    localparam logic REQ_PLAN   = 1'b0;
    localparam logic REQ_REPORT = 1'b1;

    localparam logic [9:0] US_PER_MS = 10'd1000;
    localparam logic [5:0] DIV_STEPS = 6'd32;

    typedef struct packed {
        logic load;
        logic div_start;
        logic plan_k;
        logic plan_cmp;
        logic plan_mul;
        logic plan_upd;
        logic rep_rd;
        logic rep_push;
        logic rep_base;
        logic rep_thr;
        logic rep_adapt;
        logic out_load;
    } t_afp_cmd;

    typedef struct packed {
        logic req_report;
        logic div_done;
    } t_afp_sts;

    typedef struct packed {
        logic        wait_needed;
        logic [31:0] wait_until_ms;
        logic [31:0] frames_skipped;
        logic [3:0]  take_frames;
        logic [31:0] first_timestamp;
        logic [3:0]  lead_frames;
        logic [31:0] frame_count;
    } t_afp_res;

endpackage

// File: rtl/afp_div.sv
// ----------------------------------------------------------------------------
// Adaptive frame pacer divider
// Restoring divider of a 32-bit dividend by a 7-bit divisor, one bit a cycle.
// ----------------------------------------------------------------------------
module afp_div (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [31:0] i_dividend,
    input  logic [6:0]  i_divisor,
    output logic        o_done,
    output logic [31:0] o_quotient
);
    import afp_pkg::*;

    logic [5:0]  r_cnt;
    logic        r_done;
    logic [31:0] r_quo;
    logic [6:0]  r_rem;
    logic [6:0]  r_div;
    logic [7:0]  rem_sh;
    logic        q_bit;
    logic [7:0]  n_rem;

    always_comb begin
        rem_sh = {r_rem, r_quo[31]};
        q_bit  = (rem_sh >= {1'b0, r_div});
        n_rem  = q_bit ? (rem_sh - {1'b0, r_div}) : rem_sh;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_cnt <= DIV_STEPS;
            end else if (r_cnt != '0) begin
                r_cnt <= r_cnt - 6'd1;
                if (r_cnt == 6'd1) begin
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_div <= i_divisor;
        end else if (r_cnt != '0) begin
            r_quo <= {r_quo[30:0], q_bit};
            r_rem <= n_rem[6:0];
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

// File: rtl/afp_datapath.sv
// ----------------------------------------------------------------------------
// Adaptive frame pacer datapath
// Configuration, pacing state, send-time window and result register.
// ----------------------------------------------------------------------------
module afp_datapath #(
    parameter int unsigned WINDOW_SIZE = 5
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [afp_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [afp_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  logic                               i_req_type,
    input  logic [31:0]                        i_now_ms,
    input  logic [7:0]                         i_buffered_frames,
    input  logic [23:0]                        i_send_us,
    input  logic [3:0]                         i_frames_sent,
    input  afp_pkg::t_afp_cmd                  i_cmd,
    output afp_pkg::t_afp_sts                  o_sts,
    output afp_pkg::t_afp_res                  o_res
);
    import afp_pkg::*;

    localparam int unsigned PTR_W  = (WINDOW_SIZE > 1) ? $clog2(WINDOW_SIZE) : 1;
    localparam int unsigned FILL_W = $clog2(WINDOW_SIZE + 1);
    localparam int unsigned TOT_W  = 24 + FILL_W;
    localparam int unsigned BASE_W = 17 + FILL_W;
    localparam int unsigned THR_W  = BASE_W + 4;

    logic [6:0]  r_frame_ms;
    logic [15:0] r_step;
    logic [3:0]  r_min_lead;
    logic [3:0]  r_max_lead;
    logic [31:0] r_ts_start;

    logic [31:0]       r_fi;
    logic [31:0]       r_ts;
    logic [3:0]        r_lead;
    logic [PTR_W-1:0]  r_wptr;
    logic [FILL_W-1:0] r_wfill;
    logic [TOT_W-1:0]  r_wtotal;
    logic [23:0]       r_win [WINDOW_SIZE];
    logic [23:0]       r_old;

    logic        r_req;
    logic [31:0] r_now;
    logic [7:0]  r_buf;
    logic [23:0] r_send_us;
    logic [3:0]  r_sent;

    logic signed [33:0] r_k;
    logic               r_wait;
    logic signed [33:0] r_late;
    logic [38:0]        r_until_prod;
    logic [31:0]        r_ts_inc;
    logic [BASE_W-1:0]  r_base;
    logic [THR_W-1:0]   r_thr_hi;
    logic [THR_W-1:0]   r_thr_lo;
    t_afp_res           r_res;

    logic [6:0]  fm_eff;
    logic        div_done;
    logic [31:0] quotient;
    logic        win_full;
    logic [3:0]  n_lead;
    logic [3:0]  batch;
    t_afp_res    n_res;
    logic signed [5:0] cur;
    logic signed [5:0] mn;
    logic signed [5:0] mx;

    assign fm_eff   = (r_frame_ms == 7'd0) ? 7'd1 : r_frame_ms;
    assign win_full = (r_wfill == FILL_W'(WINDOW_SIZE));

    afp_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (r_now),
        .i_divisor  (fm_eff),
        .o_done     (div_done),
        .o_quotient (quotient)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_ms <= RST_FRAME_MS;
            r_step     <= RST_TIMESTAMP_STEP;
            r_min_lead <= RST_MIN_LEAD;
            r_max_lead <= RST_MAX_LEAD;
            r_ts_start <= RST_TIMESTAMP_START;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_FRAME_MS:        r_frame_ms <= i_cfg_data[6:0];
                CFG_TIMESTAMP_STEP:  r_step     <= i_cfg_data[15:0];
                CFG_MIN_LEAD:        r_min_lead <= i_cfg_data[3:0];
                CFG_MAX_LEAD:        r_max_lead <= i_cfg_data[3:0];
                CFG_TIMESTAMP_START: r_ts_start <= i_cfg_data[31:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        mn  = $signed({2'b00, r_min_lead});
        mx  = $signed({2'b00, r_max_lead});
        cur = $signed({2'b00, r_lead});
        if (r_wtotal > TOT_W'(r_thr_hi)) begin
            cur = cur - 6'sd1;
            if (cur < mn) begin
                cur = mn;
            end
        end else if ((r_lead != 4'd0) && (r_wtotal < TOT_W'(r_thr_lo))) begin
            cur = cur + 6'sd1;
            if (cur > mx) begin
                cur = mx;
            end
        end
        if (cur < mn) begin
            cur = mn;
        end
        if (cur > mx) begin
            cur = mx;
        end
        if (cur < 6'sd0) begin
            cur = 6'sd0;
        end
        n_lead = cur[3:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fi     <= '0;
            r_ts     <= RST_TIMESTAMP_START;
            r_lead   <= RST_MIN_LEAD;
            r_wptr   <= '0;
            r_wfill  <= '0;
            r_wtotal <= '0;
        end else begin
            if (i_cmd.plan_upd && !r_wait) begin
                r_fi <= r_fi + r_late[31:0];
                r_ts <= r_ts + r_ts_inc;
            end
            if (i_cmd.rep_rd) begin
                r_fi <= r_fi + {28'd0, r_sent};
                r_ts <= r_ts + ({28'd0, r_sent} * {16'd0, r_step});
            end
            if (i_cmd.rep_push) begin
                if (!win_full) begin
                    r_wfill <= r_wfill + FILL_W'(1);
                end
                r_wtotal <= r_wtotal - (win_full ? TOT_W'(r_old) : '0)
                            + TOT_W'(r_send_us);
                if (r_wptr == PTR_W'(WINDOW_SIZE - 1)) begin
                    r_wptr <= '0;
                end else begin
                    r_wptr <= r_wptr + PTR_W'(1);
                end
            end
            if (i_cmd.rep_adapt) begin
                r_lead <= n_lead;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.rep_rd) begin
            r_old <= r_win[r_wptr];
        end
        if (i_cmd.rep_push) begin
            r_win[r_wptr] <= r_send_us;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_req     <= i_req_type;
            r_now     <= i_now_ms;
            r_buf     <= i_buffered_frames;
            r_send_us <= i_send_us;
            r_sent    <= i_frames_sent;
        end
        if (i_cmd.plan_k) begin
            r_k <= $signed({2'b00, r_fi}) - $signed({30'd0, r_lead});
        end
        if (i_cmd.plan_cmp) begin
            r_wait       <= ($signed({2'b00, quotient}) < r_k);
            r_late       <= $signed({2'b00, quotient}) - r_k;
            r_until_prod <= {7'd0, r_k[31:0]} * {32'd0, fm_eff};
        end
        if (i_cmd.plan_mul) begin
            r_ts_inc <= r_late[31:0] * {16'd0, r_step};
        end
        if (i_cmd.rep_base) begin
            r_base <= BASE_W'(fm_eff) * BASE_W'(US_PER_MS) * BASE_W'(r_wfill);
        end
        if (i_cmd.rep_thr) begin
            r_thr_hi <= THR_W'(r_base) * THR_W'(r_lead);
            r_thr_lo <= THR_W'(r_base) * THR_W'(r_lead - 4'd1);
        end
        if (i_cmd.out_load) begin
            r_res <= n_res;
        end
    end

    always_comb begin
        if (r_buf == 8'd0) begin
            batch = 4'd1;
        end else if ({4'd0, r_lead} < r_buf) begin
            batch = r_lead;
        end else begin
            batch = r_buf[3:0];
        end
        n_res.wait_needed     = 1'b0;
        n_res.wait_until_ms   = '0;
        n_res.frames_skipped  = '0;
        n_res.take_frames     = '0;
        n_res.first_timestamp = r_ts;
        n_res.lead_frames     = r_lead;
        n_res.frame_count     = r_fi;
        if (r_req == REQ_PLAN) begin
            n_res.take_frames = batch;
            if (r_wait) begin
                n_res.wait_needed   = 1'b1;
                n_res.wait_until_ms = (r_until_prod[38:32] != '0) ? '1
                                                                  : r_until_prod[31:0];
            end else begin
                n_res.frames_skipped = (r_late[33:32] != '0) ? '1 : r_late[31:0];
            end
        end
    end

    assign o_sts.req_report = (r_req == REQ_REPORT);
    assign o_sts.div_done   = div_done;
    assign o_res            = r_res;

endmodule

// File: rtl/afp_ctrl.sv
// ----------------------------------------------------------------------------
// Adaptive frame pacer controller
// Sequences the plan and report steps and owns both handshakes.
// ----------------------------------------------------------------------------
module afp_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    input  afp_pkg::t_afp_sts i_sts,
    output afp_pkg::t_afp_cmd o_cmd
);
    import afp_pkg::*;

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_DECODE   = 4'd1;
    localparam logic [3:0] S_DIV_GO   = 4'd2;
    localparam logic [3:0] S_DIV_WAIT = 4'd3;
    localparam logic [3:0] S_P_K      = 4'd4;
    localparam logic [3:0] S_P_CMP    = 4'd5;
    localparam logic [3:0] S_P_MUL    = 4'd6;
    localparam logic [3:0] S_P_UPD    = 4'd7;
    localparam logic [3:0] S_R_RD     = 4'd8;
    localparam logic [3:0] S_R_PUSH   = 4'd9;
    localparam logic [3:0] S_R_BASE   = 4'd10;
    localparam logic [3:0] S_R_THR    = 4'd11;
    localparam logic [3:0] S_R_ADAPT  = 4'd12;
    localparam logic [3:0] S_FIN      = 4'd13;

    logic [3:0] r_state;
    logic [3:0] n_state;
    logic       r_out_valid;
    logic       n_out_valid;
    t_afp_cmd   cmd;

    always_comb begin
        n_state = r_state;
        cmd     = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    cmd.load = 1'b1;
                    n_state  = S_DECODE;
                end
            end
            S_DECODE:   n_state = i_sts.req_report ? S_R_RD : S_DIV_GO;
            S_DIV_GO: begin
                cmd.div_start = 1'b1;
                n_state       = S_DIV_WAIT;
            end
            S_DIV_WAIT: begin
                if (i_sts.div_done) begin
                    n_state = S_P_K;
                end
            end
            S_P_K: begin
                cmd.plan_k = 1'b1;
                n_state    = S_P_CMP;
            end
            S_P_CMP: begin
                cmd.plan_cmp = 1'b1;
                n_state      = S_P_MUL;
            end
            S_P_MUL: begin
                cmd.plan_mul = 1'b1;
                n_state      = S_P_UPD;
            end
            S_P_UPD: begin
                cmd.plan_upd = 1'b1;
                n_state      = S_FIN;
            end
            S_R_RD: begin
                cmd.rep_rd = 1'b1;
                n_state    = S_R_PUSH;
            end
            S_R_PUSH: begin
                cmd.rep_push = 1'b1;
                n_state      = S_R_BASE;
            end
            S_R_BASE: begin
                cmd.rep_base = 1'b1;
                n_state      = S_R_THR;
            end
            S_R_THR: begin
                cmd.rep_thr = 1'b1;
                n_state     = S_R_ADAPT;
            end
            S_R_ADAPT: begin
                cmd.rep_adapt = 1'b1;
                n_state       = S_FIN;
            end
            S_FIN: begin
                if (!r_out_valid || i_out_ready) begin
                    cmd.out_load = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        if (cmd.out_load) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_cmd       = cmd;

endmodule

// File: rtl/adaptive_frame_pacer_unit.sv
// ----------------------------------------------------------------------------
// Adaptive frame pacer
// Plans frame batches against elapsed time and adapts the send-ahead lead.
// ----------------------------------------------------------------------------
// The input channel (i_valid/o_ready) takes one request word: a plan request
// with the elapsed time and buffer depth, or a report with the measured send
// time and frames sent. The output channel (o_valid/i_ready) returns one
// result word per request. Configuration is written through i_cfg_we,
// i_cfg_idx and i_cfg_data; the user must do so only while no request is
// in flight, as the block itself does not enforce it. A plan request runs
// the serial divider of the elapsed time by the frame length, then its
// target, compare, multiply and update steps. A report runs its read, push,
// base, threshold and adapt steps, one step per cycle. One request is
// processed at a time; the next word is accepted as soon as the previous
// result sits in the output register, even if it is not taken.
// When the receiver stalls, the result is held and the following request
// finishes its work and then waits until the output register frees up.
// Reset restores the default configuration, clears frame count, timestamp
// and send-time window, and sets the lead to the default minimum.
// ----------------------------------------------------------------------------
module adaptive_frame_pacer_unit #(
    parameter int unsigned WINDOW_SIZE = 5
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [afp_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [afp_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                           i_valid,
    output logic                           o_ready,
    input  logic                           i_req_type,
    input  logic [31:0]                    i_now_ms,
    input  logic [7:0]                     i_buffered_frames,
    input  logic [23:0]                    i_send_us,
    input  logic [3:0]                     i_frames_sent,
    output logic                           o_valid,
    input  logic                           i_ready,
    output logic                           o_wait_needed,
    output logic [31:0]                    o_wait_until_ms,
    output logic [31:0]                    o_frames_skipped,
    output logic [3:0]                     o_take_frames,
    output logic [31:0]                    o_first_timestamp,
    output logic [3:0]                     o_lead_frames,
    output logic [31:0]                    o_frame_count
);
    import afp_pkg::*;

    t_afp_cmd cmd;
    t_afp_sts sts;
    t_afp_res res;

    afp_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_valid),
        .o_in_ready  (o_ready),
        .o_out_valid (o_valid),
        .i_out_ready (i_ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    afp_datapath #(
        .WINDOW_SIZE (WINDOW_SIZE)
    ) u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_idx         (i_cfg_idx),
        .i_cfg_data        (i_cfg_data),
        .i_req_type        (i_req_type),
        .i_now_ms          (i_now_ms),
        .i_buffered_frames (i_buffered_frames),
        .i_send_us         (i_send_us),
        .i_frames_sent     (i_frames_sent),
        .i_cmd             (cmd),
        .o_sts             (sts),
        .o_res             (res)
    );

    assign o_wait_needed     = res.wait_needed;
    assign o_wait_until_ms   = res.wait_until_ms;
    assign o_frames_skipped  = res.frames_skipped;
    assign o_take_frames     = res.take_frames;
    assign o_first_timestamp = res.first_timestamp;
    assign o_lead_frames     = res.lead_frames;
    assign o_frame_count     = res.frame_count;

endmodule

// File: rtl/afp_checker.sv
// ----------------------------------------------------------------------------
// Adaptive frame pacer checker
// Port-level checks on request sequencing and result consistency.
// ----------------------------------------------------------------------------
module afp_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        o_ready,
    input logic        o_valid,
    input logic        i_ready,
    input logic        o_wait_needed,
    input logic [31:0] o_wait_until_ms,
    input logic [31:0] o_frames_skipped,
    input logic [31:0] o_frame_count
);

    // Only one request word is in work at a time.
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> !o_ready)
        else $error("request accepted while another is in work");

    // A waiting plan names a future time and skips nothing.
    a_wait_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_wait_needed) |-> (o_wait_until_ms != 32'd0
                                        && o_frames_skipped == 32'd0))
        else $error("waiting result carries inconsistent fields");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> o_valid)
        else $error("result word dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> $stable(o_frame_count))
        else $error("result word changed while stalled");

endmodule

bind adaptive_frame_pacer_unit afp_checker u_afp_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_valid          (i_valid),
    .o_ready          (o_ready),
    .o_valid          (o_valid),
    .i_ready          (i_ready),
    .o_wait_needed    (o_wait_needed),
    .o_wait_until_ms  (o_wait_until_ms),
    .o_frames_skipped (o_frames_skipped),
    .o_frame_count    (o_frame_count)
);

// File: tb/tb.sv
// ----------------------------------------------------------------------------
// Adaptive frame pacer testbench
// Sends plan and report requests through the valid/ready request channel,
// predicts every result word from its own model of the pacer and compares the
// words field by field. Random gaps fall on both sides of the block. One
// receiver hold-off fills the block, and the sender drains the block fully
// between configuration phases. Registers are rewritten only while idle.
// ----------------------------------------------------------------------------
module tb;
    import afp_pkg::*;

    localparam int unsigned STALL_LIMIT = 4000;
    localparam int unsigned HOLD_CYCLES = 400;
    localparam int unsigned PHASES = 10;
    localparam int unsigned PHASE_WORDS = 200;

    typedef struct {
        logic        kind;
        logic [31:0] now_ms;
        logic [7:0]  buffered;
        logic [23:0] send_us;
        logic [3:0]  sent;
    } t_pacer_req;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_idx = '0;
    logic [31:0]          cfg_data = '0;
    logic                 in_valid = 1'b0;
    logic                 req_kind = 1'b0;
    logic [31:0]          req_now = '0;
    logic [7:0]           req_buffered = '0;
    logic [23:0]          req_send_us = '0;
    logic [3:0]           req_sent = '0;
    logic                 rx_ready = 1'b0;
    logic                 o_ready;
    logic                 o_valid;
    t_afp_res             got;

    adaptive_frame_pacer_unit i_dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (cfg_we),
        .i_cfg_idx         (cfg_idx),
        .i_cfg_data        (cfg_data),
        .i_valid           (in_valid),
        .o_ready           (o_ready),
        .i_req_type        (req_kind),
        .i_now_ms          (req_now),
        .i_buffered_frames (req_buffered),
        .i_send_us         (req_send_us),
        .i_frames_sent     (req_sent),
        .o_valid           (o_valid),
        .i_ready           (rx_ready),
        .o_wait_needed     (got.wait_needed),
        .o_wait_until_ms   (got.wait_until_ms),
        .o_frames_skipped  (got.frames_skipped),
        .o_take_frames     (got.take_frames),
        .o_first_timestamp (got.first_timestamp),
        .o_lead_frames     (got.lead_frames),
        .o_frame_count     (got.frame_count)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Configuration and state of the pacer as the testbench sees it.
    logic [6:0]  cfg_frame_ms = RST_FRAME_MS;
    logic [15:0] cfg_ts_step = RST_TIMESTAMP_STEP;
    logic [3:0]  cfg_min_lead = RST_MIN_LEAD;
    logic [3:0]  cfg_max_lead = RST_MAX_LEAD;
    logic [31:0] cfg_ts_start = RST_TIMESTAMP_START;
    logic [31:0] frame_pos = '0;
    logic [31:0] stream_ts = RST_TIMESTAMP_START;
    logic [3:0]  lead_now = RST_MIN_LEAD;
    logic [23:0] send_window [5];
    int unsigned win_ptr = 0;
    int unsigned win_count = 0;
    longint      win_sum = 0;

    t_pacer_req  pending_reqs [$];
    t_afp_res    pending_results [$];
    t_pacer_req  cur_req;
    t_afp_res    want;
    bit          offering = 1'b0;
    bit          no_idle = 1'b0;
    int unsigned send_gap = 0;
    int unsigned rx_stall = 0;
    int unsigned hold_request = 0;
    int unsigned mismatch_count = 0;
    int unsigned idle_cycles = 0;
    longint      gen_frames = 0;
    longint      lead_guess = 2;

    initial begin
        for (int k = 0; k < 5; k++) begin
            send_window[k] = '0;
        end
    end

    function automatic t_afp_res advance_pacer(input t_pacer_req r);
        t_afp_res          res;
        longint            fm;
        longint            ideal;
        longint            cur;
        longint            cnt;
        longint            mn_l;
        longint            mx_l;
        longint            us_l;
        longint unsigned   late;
        int unsigned       p;
        res = '0;
        fm = (cfg_frame_ms == 0) ? 1 : longint'({25'd0, cfg_frame_ms});
        if (r.kind == REQ_PLAN) begin
            ideal = (longint'({32'd0, frame_pos}) - longint'({28'd0, lead_now})) * fm;
            if (longint'({32'd0, r.now_ms}) < ideal) begin
                res.wait_needed = 1'b1;
                res.wait_until_ms = (ideal > 64'shFFFFFFFF) ? 32'hFFFFFFFF : ideal[31:0];
            end else begin
                late = longint'(longint'({32'd0, r.now_ms}) - ideal) / fm;
                frame_pos = frame_pos + late[31:0];
                stream_ts = stream_ts + late[31:0] * {16'd0, cfg_ts_step};
                res.frames_skipped = (late > 64'hFFFFFFFF) ? 32'hFFFFFFFF : late[31:0];
            end
            if (r.buffered == 0) begin
                res.take_frames = 4'd1;
            end else begin
                res.take_frames = ({4'd0, lead_now} < r.buffered) ? lead_now : r.buffered[3:0];
            end
        end else begin
            frame_pos = frame_pos + {28'd0, r.sent};
            stream_ts = stream_ts + {28'd0, r.sent} * {16'd0, cfg_ts_step};
            p = win_ptr % 5;
            if (win_count < 5) begin
                win_count++;
            end else begin
                win_sum -= longint'({40'd0, send_window[p]});
            end
            send_window[p] = r.send_us;
            win_sum += longint'({40'd0, r.send_us});
            win_ptr = (p + 1) % 5;
            cur = longint'({28'd0, lead_now});
            cnt = longint'(win_count);
            mn_l = longint'({28'd0, cfg_min_lead});
            mx_l = longint'({28'd0, cfg_max_lead});
            us_l = longint'({22'd0, US_PER_MS});
            if (win_sum > fm * us_l * cur * cnt) begin
                cur = cur - 1;
                if (cur < mn_l) cur = mn_l;
            end else if (win_sum < fm * us_l * (cur - 1) * cnt) begin
                cur = cur + 1;
                if (cur > mx_l) cur = mx_l;
            end
            if (cur < mn_l) cur = mn_l;
            if (cur > mx_l) cur = mx_l;
            if (cur < 0) cur = 0;
            lead_now = cur[3:0];
        end
        res.first_timestamp = stream_ts;
        res.lead_frames = lead_now;
        res.frame_count = frame_pos;
        return res;
    endfunction

    function automatic int unsigned pick_gap();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (no_idle || roll < 55) return 0;
        if (roll < 85) return $urandom_range(1, 3);
        if (roll < 97) return $urandom_range(4, 15);
        return $urandom_range(16, 80);
    endfunction

    task automatic flag_mismatch(input string what, input logic [31:0] exp_v,
                                 input logic [31:0] act_v);
        mismatch_count++;
        if (mismatch_count <= 10) begin
            $display("mismatch in %s: expected 0x%08h, got 0x%08h", what, exp_v, act_v);
        end
    endtask

    // Request sender.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_valid <= 1'b0;
            offering = 1'b0;
        end else begin
            if (offering && o_ready) begin
                pending_results.push_back(advance_pacer(cur_req));
                offering = 1'b0;
                send_gap = pick_gap();
            end
            if (!offering) begin
                if (send_gap > 0) begin
                    send_gap--;
                end else if (pending_reqs.size() > 0) begin
                    cur_req = pending_reqs.pop_front();
                    offering = 1'b1;
                    req_kind <= cur_req.kind;
                    req_now <= cur_req.now_ms;
                    req_buffered <= cur_req.buffered;
                    req_send_us <= cur_req.send_us;
                    req_sent <= cur_req.sent;
                end
            end
            in_valid <= offering;
        end
    end

    // Result receiver and checker.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rx_ready <= 1'b0;
        end else begin
            if (o_valid && rx_ready) begin
                if (pending_results.size() == 0) begin
                    flag_mismatch("unexpected result word", '0, got.frame_count);
                end else begin
                    want = pending_results.pop_front();
                    if (got.wait_needed !== want.wait_needed)
                        flag_mismatch("wait_needed", 32'(want.wait_needed),
                                      32'(got.wait_needed));
                    if (got.wait_until_ms !== want.wait_until_ms)
                        flag_mismatch("wait_until_ms", want.wait_until_ms, got.wait_until_ms);
                    if (got.frames_skipped !== want.frames_skipped)
                        flag_mismatch("frames_skipped", want.frames_skipped, got.frames_skipped);
                    if (got.take_frames !== want.take_frames)
                        flag_mismatch("take_frames", 32'(want.take_frames),
                                      32'(got.take_frames));
                    if (got.first_timestamp !== want.first_timestamp)
                        flag_mismatch("first_timestamp", want.first_timestamp,
                                      got.first_timestamp);
                    if (got.lead_frames !== want.lead_frames)
                        flag_mismatch("lead_frames", 32'(want.lead_frames),
                                      32'(got.lead_frames));
                    if (got.frame_count !== want.frame_count)
                        flag_mismatch("frame_count", want.frame_count, got.frame_count);
                end
                rx_stall = pick_gap();
            end
            if (hold_request > 0) begin
                rx_stall = hold_request;
                hold_request = 0;
            end
            if (rx_stall > 0) begin
                rx_stall--;
                rx_ready <= 1'b0;
            end else begin
                rx_ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        if ((in_valid && o_ready) || (o_valid && rx_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles == STALL_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
        @(posedge i_clk);
        cfg_we <= 1'b1;
        cfg_idx <= idx;
        cfg_data <= data;
        case (idx)
            CFG_FRAME_MS: cfg_frame_ms = data[6:0];
            CFG_TIMESTAMP_STEP: cfg_ts_step = data[15:0];
            CFG_MIN_LEAD: cfg_min_lead = data[3:0];
            CFG_MAX_LEAD: cfg_max_lead = data[3:0];
            CFG_TIMESTAMP_START: cfg_ts_start = data;
            default: ;
        endcase
        @(posedge i_clk);
        cfg_we <= 1'b0;
    endtask

    task automatic set_config(input logic [6:0] fm, input logic [15:0] step,
                              input logic [3:0] mn, input logic [3:0] mx,
                              input logic [31:0] start);
        write_reg(CFG_FRAME_MS, {25'd0, fm});
        write_reg(CFG_TIMESTAMP_STEP, {16'd0, step});
        write_reg(CFG_MIN_LEAD, {28'd0, mn});
        write_reg(CFG_MAX_LEAD, {28'd0, mx});
        write_reg(CFG_TIMESTAMP_START, start);
    endtask

    task automatic queue_plan(input logic [31:0] now, input logic [7:0] buffered);
        t_pacer_req r;
        r.kind = REQ_PLAN;
        r.now_ms = now;
        r.buffered = buffered;
        r.send_us = 24'($urandom());
        r.sent = 4'($urandom());
        pending_reqs.push_back(r);
    endtask

    task automatic queue_report(input logic [23:0] send_us, input logic [3:0] sent);
        t_pacer_req r;
        r.kind = REQ_REPORT;
        r.now_ms = $urandom();
        r.buffered = 8'($urandom());
        r.send_us = send_us;
        r.sent = sent;
        pending_reqs.push_back(r);
    endtask

    task automatic wait_drained();
        while (pending_reqs.size() != 0 || offering || pending_results.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (4) @(posedge i_clk);
    endtask

    // Mostly plan/report pairs timed around the ideal send time, with some
    // malformed requests and a few wild timestamps at the end of the stream.
    task automatic queue_traffic(input int unsigned count);
        longint      fm_g;
        longint      t;
        longint      ideal_g;
        int unsigned roll;
        bit          plan_next;
        logic [7:0]  buffered;
        logic [23:0] us;
        logic [3:0]  sent;
        fm_g = (cfg_frame_ms == 0) ? 1 : longint'({25'd0, cfg_frame_ms});
        plan_next = 1'b1;
        for (int unsigned i = 0; i < count; i++) begin
            roll = $urandom_range(0, 99);
            if (i + 3 >= count && $urandom_range(0, 1) == 1) begin
                queue_plan($urandom(), 8'($urandom()));
            end else if (roll < 6) begin
                if ($urandom_range(0, 1) == 1) begin
                    queue_report(24'($urandom()), 4'($urandom()));
                end else begin
                    t = (gen_frames + longint'($urandom_range(0, 60))) * fm_g;
                    if (t > 64'shFFFFFFFF) t = 64'shFFFFFFFF;
                    queue_plan(t[31:0], 8'($urandom()));
                    gen_frames = t / fm_g + lead_guess;
                end
            end else if (plan_next) begin
                ideal_g = (gen_frames - lead_guess) * fm_g;
                t = ideal_g - 2 * fm_g + longint'($urandom_range(0, 5)) * fm_g
                    + longint'($urandom_range(0, 1) * $urandom_range(0, 32'(fm_g) - 1));
                if (t < 0) t = 0;
                if (t > 64'shFFFFFFFF) t = 64'shFFFFFFFF;
                roll = $urandom_range(0, 9);
                if (roll < 7) buffered = 8'($urandom_range(0, 8));
                else if (roll < 9) buffered = 8'($urandom());
                else buffered = '0;
                queue_plan(t[31:0], buffered);
                if (t >= ideal_g) gen_frames += (t - ideal_g) / fm_g;
                plan_next = 1'b0;
            end else begin
                sent = ($urandom_range(0, 9) < 7) ? 4'($urandom_range(0, 4))
                                                  : 4'($urandom());
                roll = $urandom_range(0, 99);
                if (roll < 60) begin
                    t = fm_g * 1000 * longint'($urandom_range(0, 32'(lead_guess) + 2));
                    t = t + longint'($urandom_range(0, 999));
                    us = (t > 64'shFFFFFF) ? 24'hFFFFFF : t[23:0];
                end else if (roll < 85) begin
                    us = 24'($urandom());
                end else begin
                    us = ($urandom_range(0, 1) == 1) ? 24'hFFFFFF : 24'h000000;
                end
                queue_report(us, sent);
                gen_frames += longint'(sent);
                plan_next = 1'b1;
            end
        end
    endtask

    task automatic run_phase(input bit quiet, input bit with_hold);
        no_idle = quiet;
        gen_frames = longint'({32'd0, frame_pos});
        lead_guess = longint'({28'd0, lead_now});
        queue_traffic(PHASE_WORDS / 2);
        if (with_hold) hold_request = HOLD_CYCLES;
        wait_drained();
        gen_frames = longint'({32'd0, frame_pos});
        lead_guess = longint'({28'd0, lead_now});
        queue_traffic(PHASE_WORDS / 2);
        wait_drained();
    endtask

    initial begin
        logic [3:0] mn;
        logic [3:0] mx;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (3) @(posedge i_clk);

        // A zero frame length counts as one millisecond.
        write_reg(CFG_FRAME_MS, 32'd0);
        queue_plan(32'hFFFFFFFF, 8'd0);
        queue_plan(32'd0, 8'd255);
        queue_report(24'h000000, 4'd15);
        queue_report(24'hFFFFFF, 4'd15);
        queue_plan(32'd0, 8'd1);
        wait_drained();

        write_reg(CFG_FRAME_MS, 32'd120);
        queue_plan(32'hFFFFFFFF, 8'd8);
        queue_report(24'h555555, 4'd15);
        queue_plan(32'd0, 8'd4);
        queue_report(24'hAAAAAA, 4'd1);
        queue_report(24'h000001, 4'd2);
        queue_report(24'h000002, 4'd3);
        queue_report(24'h7FFFFF, 4'd4);
        wait_drained();

        write_reg(CFG_MIN_LEAD, 32'd0);
        write_reg(CFG_MAX_LEAD, 32'd0);
        queue_report(24'h000000, 4'd0);
        queue_plan(32'd0, 8'd5);
        queue_plan(32'hFFFFFFFF, 8'd5);
        wait_drained();

        write_reg(CFG_MIN_LEAD, 32'd15);
        write_reg(CFG_MAX_LEAD, 32'd1);
        queue_report(24'h000000, 4'd0);
        queue_plan(32'hFFFFFFFF, 8'd200);
        wait_drained();

        write_reg(CFG_TIMESTAMP_STEP, 32'd65535);
        write_reg(CFG_TIMESTAMP_START, 32'hFFFFFFFF);
        queue_report(24'h000007, 4'd15);
        queue_plan(32'd0, 8'd0);
        wait_drained();

        for (int unsigned ph = 0; ph < PHASES; ph++) begin
            case (ph)
                0: set_config(7'd20, 16'd960, 4'd2, 4'd4, 32'd0);
                1: set_config(7'd1, 16'd1, 4'd1, 4'd15, 32'hFFFFFFFF);
                2: set_config(7'd120, 16'd65535, 4'd15, 4'd15, $urandom());
                3: set_config(7'd10, 16'($urandom()), 4'd1, 4'd1, $urandom());
                default: begin
                    mn = 4'($urandom_range(1, 15));
                    mx = ($urandom_range(0, 4) == 0) ? 4'($urandom_range(1, 15))
                                                     : 4'($urandom_range(mn, 15));
                    set_config(7'($urandom_range(1, 120)), 16'($urandom_range(1, 65535)),
                               mn, mx, $urandom());
                end
            endcase
            run_phase(ph == 4 || ph == 7, ph == 2);
        end

        wait_drained();
        repeat (60) @(posedge i_clk);
        if (mismatch_count == 0 && pending_results.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end
endmodule
